FILE: rtl/srs_pkg.sv
// shared types and constants of the stripe request splitter
// used by srs_ctrl, srs_datapath and stripe_request_splitter_top
`timescale 1ns / 1ps

package srs_pkg;

    localparam int OFF_W       = 48;
    localparam int BCNT_W      = 32;
    localparam int SIZE_W      = 27;
    localparam int SCNT_W      = 9;
    localparam int IDX_OUT_W   = 8;
    localparam int LEN_W       = 27;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 88;
    localparam int OUT_TUSER_W = 2;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 27;

    localparam int DIV_STEPS   = 48;
    localparam int STEP_W      = 6;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 27'd1048576;
    localparam logic [SIZE_W-1:0] SIZE_MAX   = 27'd67108864;
    localparam logic [SCNT_W-1:0] SCNT_RESET = 9'd1;

    localparam logic [CFG_IDX_W-1:0] REG_STRIPE_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIPE_COUNT = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_SIZE,
        ST_SETUP_CNT,
        ST_DIV_CNT,
        ST_FINISH,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic div_sel_cnt;
        logic init_cnt;
        logic finish;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic in_zero;
        logic step_last;
        logic out_free;
        logic piece_end;
    } t_status;

endpackage

FILE: rtl/srs_ctrl.sv
// sequencer of the stripe request splitter: accept, two divisions, piece emission
// depends on srs_pkg
`timescale 1ns / 1ps

module srs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  srs_pkg::t_status i_status,
    output srs_pkg::t_cmd    o_cmd
);
    import srs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (!i_status.in_zero) begin
                        n_state = ST_DIV_SIZE;
                    end
                end
            end
            ST_DIV_SIZE: begin
                o_cmd.div_step = 1'b1;
                if (i_status.step_last) begin
                    n_state = ST_SETUP_CNT;
                end
            end
            ST_SETUP_CNT: begin
                o_cmd.init_cnt = 1'b1;
                n_state        = ST_DIV_CNT;
            end
            ST_DIV_CNT: begin
                o_cmd.div_step    = 1'b1;
                o_cmd.div_sel_cnt = 1'b1;
                if (i_status.step_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.piece_end) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/srs_datapath.sv
// datapath of the stripe request splitter: config registers, shared bit-serial
// divider, piece walker and output register; depends on srs_pkg
`timescale 1ns / 1ps

module srs_datapath #(
    parameter int MAX_PIECES  = 64,
    parameter int MAX_STRIPES = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  srs_pkg::t_cmd                   i_cmd,
    output srs_pkg::t_status                o_status,
    input  logic                            i_cfg_valid,
    input  logic [srs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [srs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_kind,
    input  logic [srs_pkg::OFF_W-1:0]       i_file_offset,
    input  logic [srs_pkg::BCNT_W-1:0]      i_byte_count,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic                            o_piece_kind,
    output logic [srs_pkg::IDX_OUT_W-1:0]   o_stripe_index,
    output logic [srs_pkg::OFF_W-1:0]       o_object_offset,
    output logic [srs_pkg::LEN_W-1:0]       o_piece_length,
    output logic                            o_last,
    output logic                            o_truncated
);
    import srs_pkg::*;

    localparam int IW = (MAX_STRIPES > 1) ? $clog2(MAX_STRIPES) : 1;
    localparam int CW = $clog2(MAX_STRIPES + 1);
    localparam int PW = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;

    logic [SIZE_W-1:0] r_size;
    logic [SCNT_W-1:0] r_scnt;

    logic [SIZE_W-1:0] eff_size;
    logic [31:0]       scnt_w;
    logic [CW-1:0]     eff_cnt;

    logic [OFF_W-1:0]  r_dq;
    logic [SIZE_W-1:0] r_rem;
    logic [OFF_W-1:0]  r_acc;
    logic [SIZE_W-1:0] r_r;
    logic [STEP_W-1:0] r_step;

    logic [BCNT_W-1:0] r_left;
    logic              r_kind;
    logic [PW-1:0]     r_n;
    logic [IW-1:0]     r_idx;
    logic [OFF_W-1:0]  r_ooff;

    logic                 r_ovalid;
    logic                 r_o_kind;
    logic [IDX_OUT_W-1:0] r_o_idx;
    logic [OFF_W-1:0]     r_o_ooff;
    logic [LEN_W-1:0]     r_o_len;
    logic                 r_o_last;
    logic                 r_o_trunc;

    logic [SIZE_W-1:0] divisor;
    logic [SIZE_W:0]   trial;
    logic [SIZE_W:0]   diff;
    logic              qbit;
    logic [SIZE_W-1:0] n_rem;

    logic [LEN_W-1:0]  len;
    logic [BCNT_W-1:0] n_left;
    logic              at_end;
    logic [CW-1:0]     idx_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
            r_scnt <= SCNT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_STRIPE_SIZE:  r_size <= i_cfg_data[SIZE_W-1:0];
                REG_STRIPE_COUNT: r_scnt <= i_cfg_data[SCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_size == '0) begin
            eff_size = SIZE_W'(1);
        end else if (r_size > SIZE_MAX) begin
            eff_size = SIZE_MAX;
        end else begin
            eff_size = r_size;
        end
        scnt_w = 32'(r_scnt);
        if (scnt_w == 32'd0) begin
            eff_cnt = CW'(1);
        end else if (scnt_w > 32'(MAX_STRIPES)) begin
            eff_cnt = CW'(MAX_STRIPES);
        end else begin
            eff_cnt = scnt_w[CW-1:0];
        end
    end

    // one restoring division step, quotient bits shift in from the bottom
    always_comb begin
        divisor = i_cmd.div_sel_cnt ? SIZE_W'(eff_cnt) : eff_size;
        trial   = {r_rem, r_dq[OFF_W-1]};
        diff    = trial - {1'b0, divisor};
        qbit    = (trial >= {1'b0, divisor});
        n_rem   = qbit ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
    end

    always_comb begin
        if (r_left < BCNT_W'(eff_size)) begin
            len = r_left[LEN_W-1:0];
        end else begin
            len = eff_size;
        end
        n_left  = r_left - BCNT_W'(len);
        at_end  = (n_left == '0) || (r_n == PW'(MAX_PIECES - 1));
        idx_inc = CW'(r_idx) + CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dq   <= i_file_offset;
            r_rem  <= '0;
            r_step <= '0;
            r_left <= i_byte_count;
            r_kind <= i_kind;
            r_n    <= '0;
        end else if (i_cmd.div_step) begin
            r_dq   <= {r_dq[OFF_W-2:0], qbit};
            r_rem  <= n_rem;
            r_step <= r_step + STEP_W'(1);
            // object base: quotient by count times stripe size, built msb first
            if (i_cmd.div_sel_cnt) begin
                r_acc <= {r_acc[OFF_W-2:0], 1'b0} + (qbit ? OFF_W'(eff_size) : '0);
            end
        end else if (i_cmd.init_cnt) begin
            r_r    <= r_rem;
            r_rem  <= '0;
            r_acc  <= '0;
            r_step <= '0;
        end else if (i_cmd.finish) begin
            r_idx  <= r_rem[IW-1:0];
            r_ooff <= r_acc + OFF_W'(r_r);
        end else if (i_cmd.emit) begin
            r_left <= n_left;
            r_n    <= r_n + PW'(1);
            if (idx_inc == eff_cnt) begin
                r_idx  <= '0;
                r_ooff <= r_ooff + OFF_W'(eff_size);
            end else begin
                r_idx  <= idx_inc[IW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_kind  <= r_kind;
            r_o_idx   <= IDX_OUT_W'(r_idx);
            r_o_ooff  <= r_ooff;
            r_o_len   <= len;
            r_o_last  <= at_end;
            r_o_trunc <= at_end && (n_left != '0);
        end
    end

    always_comb begin
        o_status.in_zero   = (i_byte_count == '0);
        o_status.step_last = (r_step == STEP_W'(DIV_STEPS - 1));
        o_status.out_free  = !r_ovalid || i_out_ready;
        o_status.piece_end = at_end;
    end

    assign o_out_valid     = r_ovalid;
    assign o_piece_kind    = r_o_kind;
    assign o_stripe_index  = r_o_idx;
    assign o_object_offset = r_o_ooff;
    assign o_piece_length  = r_o_len;
    assign o_last          = r_o_last;
    assign o_truncated     = r_o_trunc;

`ifndef SYNTHESIS
    a_emit_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_ovalid || i_out_ready))
        else $error("piece loaded over a result not yet taken");

    a_emit_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_left != '0))
        else $error("piece emitted with no bytes left");

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(i_cmd.emit))
        else $error("output valid rose without a piece load");
`endif

endmodule

FILE: rtl/stripe_request_splitter_top.sv
// top level of the stripe request splitter
// depends on srs_pkg, srs_ctrl and srs_datapath
//
// channel   direction  content
// s_axis    in         request item: tuser kind, tdata offset and byte count
// m_axis    out        piece item: tuser kind and truncated, tlast last piece
// cfg       in         register write: index, data
//
// a request is accepted in idle, then runs the shared bit-serial divider
// (offset by stripe size, then quotient by stripe count) through the states
// div_size, setup_cnt, div_cnt and finish, then one piece per cycle while m_axis takes them.
// a zero byte count is accepted and gives no pieces.
// reset restores stripe size 1048576 and stripe count 1; m_axis stalls hold
// the piece walk, and a new request is taken while the last piece still waits
`timescale 1ns / 1ps

module stripe_request_splitter_top #(
    parameter int MAX_PIECES  = 64,
    parameter int MAX_STRIPES = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [srs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // file_offset, byte_count
    input  logic                              s_axis_tuser,  // kind
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [srs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // stripe_index, object_offset,
                                                             // piece_length, zero pad
    output logic [srs_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,  // piece_kind, truncated
    output logic                              m_axis_tlast,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [srs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [srs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import srs_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    logic                 piece_kind;
    logic [IDX_OUT_W-1:0] stripe_index;
    logic [OFF_W-1:0]     object_offset;
    logic [LEN_W-1:0]     piece_length;
    logic                 truncated;

    srs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    srs_datapath #(
        .MAX_PIECES  (MAX_PIECES),
        .MAX_STRIPES (MAX_STRIPES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_kind          (s_axis_tuser),
        .i_file_offset   (s_axis_tdata[OFF_W-1:0]),
        .i_byte_count    (s_axis_tdata[OFF_W+BCNT_W-1:OFF_W]),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_piece_kind    (piece_kind),
        .o_stripe_index  (stripe_index),
        .o_object_offset (object_offset),
        .o_piece_length  (piece_length),
        .o_last          (m_axis_tlast),
        .o_truncated     (truncated)
    );

    assign s_axis_tready = in_ready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tdata  = {5'b0, piece_length, object_offset, stripe_index};
    assign m_axis_tuser  = {truncated, piece_kind};

endmodule
